// ----- rtl/bofm_pkg.sv -----
// ---------------------------------------------------------------------------
// bofm_pkg: shared types and constants for the byte order field marshaller.
// Holds the store geometry, mode and status codes and the kind tables.
// ---------------------------------------------------------------------------
package bofm_pkg;

   localparam int DEPTH = 4096;
   localparam int AW    = $clog2(DEPTH);   // store address width
   localparam int PW    = 13;              // cursor and fill width

   localparam logic [1:0] MODE_WRITE  = 2'd0;
   localparam logic [1:0] MODE_READ   = 2'd1;
   localparam logic [1:0] MODE_CURSOR = 2'd2;
   localparam logic [1:0] MODE_CLEAR  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_OOB   = 2'd1;
   localparam logic [1:0] ST_SPACE = 2'd2;

   localparam logic [2:0] REG_INT16 = 3'd0;
   localparam logic [2:0] REG_INT32 = 3'd1;
   localparam logic [2:0] REG_INT64 = 3'd2;
   localparam logic [2:0] REG_FLT32 = 3'd3;
   localparam logic [2:0] REG_FLT64 = 3'd4;
   localparam logic [2:0] REG_NONE  = 3'd5;

   localparam logic [31:0] MAP_RESET16 = 32'h0000_0010;
   localparam logic [31:0] MAP_RESET32 = 32'h0000_3210;
   localparam logic [31:0] MAP_RESET64 = 32'h7654_3210;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  kind;
      logic [63:0] write_value;
      logic [13:0] cursor_target;
   } req_type;

   typedef struct packed {
      logic [63:0] read_value;
      logic [1:0]  status;
      logic [12:0] cursor_now;
      logic [12:0] fill_now;
   } rsp_type;

   // Width in bytes; zero marks an unknown kind.
   function automatic logic [3:0] kind_width(input logic [3:0] kind);
      logic [3:0] w;
      unique case (kind)
         4'd0, 4'd1:       w = 4'd1;
         4'd2, 4'd3:       w = 4'd2;
         4'd4, 4'd5, 4'd8: w = 4'd4;
         4'd6, 4'd7, 4'd9: w = 4'd8;
         default:          w = 4'd0;
      endcase
      return w;
   endfunction

   function automatic logic [2:0] kind_map(input logic [3:0] kind);
      logic [2:0] m;
      unique case (kind)
         4'd2, 4'd3: m = REG_INT16;
         4'd4, 4'd5: m = REG_INT32;
         4'd6, 4'd7: m = REG_INT64;
         4'd8:       m = REG_FLT32;
         4'd9:       m = REG_FLT64;
         default:    m = REG_NONE;
      endcase
      return m;
   endfunction

   function automatic logic kind_signed(input logic [3:0] kind);
      return (kind == 4'd0) || (kind == 4'd2) || (kind == 4'd4) || (kind == 4'd6);
   endfunction

endpackage

// ----- rtl/bofm_if.sv -----
// ---------------------------------------------------------------------------
// bofm_if: valid/ready channel carrying one payload beat.
// Declared once for the request and once for the response side.
// ---------------------------------------------------------------------------
interface bofm_req_if;
   logic              valid;
   logic              ready;
   bofm_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface bofm_rsp_if;
   logic              valid;
   logic              ready;
   bofm_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/byte_order_field_marshaller.sv -----
// ---------------------------------------------------------------------------
// byte_order_field_marshaller: endian-configurable pack/unpack byte buffer.
// A byte-wide store with cursor and fill length, driven by a small sequencer.
// ---------------------------------------------------------------------------
//  channel  direction  beat contents
//  req      in         mode, kind, write_value, cursor_target
//  rsp      out        read_value, status, cursor_now, fill_now
//  csr      in         APB writes/reads of the five order maps
//
// One byte-wide store port sets the pace: a write stores each byte, a read
// addresses then captures each byte, and a prepend of N copies the fill up N
// from the top, then zeroes the first N. After reset, and for a buffer reset
// item, a clearing pass zeroes the store; no request is taken meanwhile. One
// item is in work at a time; req_ready stays low until the response is taken.
module byte_order_field_marshaller (
   input  logic               clock,
   input  logic               reset,
   bofm_req_if.sink           req,
   bofm_rsp_if.source         rsp,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int AW = bofm_pkg::AW;
   localparam int PW = bofm_pkg::PW;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WRITE = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_MOVE  = 3'd3;
   localparam logic [2:0] S_ZERO  = 3'd4;
   localparam logic [2:0] S_CLEAR = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   // Order map registers.
   logic [31:0] map_ff [5];
   logic [2:0]  csr_idx;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff[0] <= bofm_pkg::MAP_RESET16;
         map_ff[1] <= bofm_pkg::MAP_RESET32;
         map_ff[2] <= bofm_pkg::MAP_RESET64;
         map_ff[3] <= bofm_pkg::MAP_RESET32;
         map_ff[4] <= bofm_pkg::MAP_RESET64;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_idx < bofm_pkg::REG_NONE) begin
         map_ff[csr_idx] <= csr_pwdata;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_idx < bofm_pkg::REG_NONE) begin
         csr_prdata = map_ff[csr_idx];
      end
   end

   // Byte store: one port, registered read data.
   logic [7:0]    mem [bofm_pkg::DEPTH];
   logic          mem_we;
   logic [AW-1:0] mem_addr;
   logic [7:0]    mem_wdata;
   logic [7:0]    mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_addr];
   end

   // Sequencer state.
   logic [2:0]    state_ff, state_in;
   logic [PW-1:0] cur_ff, cur_in;
   logic [PW-1:0] fill_ff, fill_in;
   logic [PW:0]   cnt_ff, cnt_in;      // byte index or sweep address
   logic          phase_ff, phase_in;  // address-then-capture step of a read, read-then-write step of a move
   logic [PW-1:0] amt_ff, amt_in;
   bofm_pkg::req_type req_ff, req_in;
   bofm_pkg::rsp_type rsp_ff, rsp_in;
   logic          from_reset_ff;

   logic [3:0]    w;
   logic [31:0]   map_sel;
   logic [3:0]    nib;
   logic [2:0]    off;
   logic [PW-1:0] byte_addr;

   assign w     = bofm_pkg::kind_width(req_ff.kind);

   always_comb begin
      map_sel = '0;
      if (bofm_pkg::kind_map(req_ff.kind) < bofm_pkg::REG_NONE) begin
         map_sel = map_ff[bofm_pkg::kind_map(req_ff.kind)];
      end
      nib = map_sel[{cnt_ff[2:0], 2'b00} +: 4];
      off = nib[2:0] & 3'(w - 4'd1);
      byte_addr = cur_ff + PW'(off);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      fill_in  = fill_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      amt_in   = amt_ff;
      req_in   = req_ff;
      rsp_in   = rsp_ff;
      mem_we   = 1'b0;
      mem_addr = byte_addr[AW-1:0];
      mem_wdata = req_ff.write_value[{cnt_ff[2:0], 3'b000} +: 8];
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               req_in = req.data;
               cnt_in = '0;
               phase_in = 1'b0;
               rsp_in = '0;
               state_in = S_RESP;
               priority case (req.data.mode)
                  bofm_pkg::MODE_WRITE: begin
                     if (bofm_pkg::kind_width(req.data.kind) == 4'd0) begin
                        state_in = S_RESP;
                     end else if ({1'b0, cur_ff} + (PW + 1)'(bofm_pkg::kind_width(req.data.kind))
                                  > (PW + 1)'(bofm_pkg::DEPTH)) begin
                        rsp_in.status = bofm_pkg::ST_SPACE;
                     end else begin
                        state_in = S_WRITE;
                     end
                  end
                  bofm_pkg::MODE_READ: begin
                     if (bofm_pkg::kind_width(req.data.kind) == 4'd0) begin
                        state_in = S_RESP;
                     end else if ({1'b0, cur_ff} + (PW + 1)'(bofm_pkg::kind_width(req.data.kind))
                                  > {1'b0, fill_ff}) begin
                        rsp_in.status = bofm_pkg::ST_OOB;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  bofm_pkg::MODE_CURSOR: begin
                     if (req.data.cursor_target[13]) begin
                        if ({1'b0, fill_ff} + (PW + 1)'(14'h0 - req.data.cursor_target)
                            > (PW + 1)'(bofm_pkg::DEPTH)) begin
                           rsp_in.status = bofm_pkg::ST_SPACE;
                        end else begin
                           amt_in = PW'(14'h0 - req.data.cursor_target);
                           cnt_in = {1'b0, fill_ff};
                           state_in = (fill_ff == '0) ? S_ZERO : S_MOVE;
                           if (fill_ff == '0) cnt_in = '0;
                        end
                     end else if ((PW + 1)'(req.data.cursor_target) + 1'b1
                                  > (PW + 1)'(bofm_pkg::DEPTH)) begin
                        rsp_in.status = bofm_pkg::ST_SPACE;
                     end else begin
                        cur_in = PW'(req.data.cursor_target);
                        if (PW'(req.data.cursor_target) > fill_ff)
                           fill_in = PW'(req.data.cursor_target);
                     end
                  end
                  default: begin
                     cur_in = '0;
                     fill_in = '0;
                     cnt_in = '0;
                     state_in = S_CLEAR;
                  end
               endcase
            end
         end
         S_WRITE: begin
            // One value byte per cycle, ascending so repeats keep the last.
            mem_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[3:0] == w - 4'd1) begin
               cur_in = cur_ff + PW'(w);
               if (cur_ff + PW'(w) > fill_ff) fill_in = cur_ff + PW'(w);
               state_in = S_RESP;
            end
         end
         S_READ: begin
            // Address in phase 0, capture data in phase 1.
            phase_in = ~phase_ff;
            if (phase_ff) begin
               rsp_in.read_value[{cnt_ff[2:0], 3'b000} +: 8] = mem_rdata_ff;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff[3:0] == w - 4'd1) begin
                  if (bofm_pkg::kind_signed(req_ff.kind) && w != 4'd8
                      && mem_rdata_ff[7]) begin
                     for (int b = 1; b < 8; b++) begin
                        if (b > int'(cnt_ff[2:0])) rsp_in.read_value[b*8 +: 8] = 8'hFF;
                     end
                  end
                  cur_in = cur_ff + PW'(w);
                  state_in = S_RESP;
               end
            end
         end
         S_MOVE: begin
            // Copy from the top down: read byte k-1, write it at k-1+amount.
            if (!phase_ff) begin
               mem_addr = AW'(cnt_ff - 1'b1);
               phase_in = 1'b1;
            end else begin
               mem_we = 1'b1;
               mem_addr = AW'(cnt_ff - 1'b1 + (PW + 1)'(amt_ff));
               mem_wdata = mem_rdata_ff;
               phase_in = 1'b0;
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == (PW + 1)'(1)) begin
                  cnt_in = '0;
                  state_in = S_ZERO;
               end
            end
         end
         S_ZERO: begin
            mem_we = 1'b1;
            mem_addr = AW'(cnt_ff);
            mem_wdata = 8'h00;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (PW + 1)'(amt_ff) - 1'b1) begin
               fill_in = fill_ff + amt_ff;
               cur_in = '0;
               state_in = S_RESP;
            end
         end
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_addr = AW'(cnt_ff);
            mem_wdata = 8'h00;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (PW + 1)'(bofm_pkg::DEPTH - 1)) state_in = S_RESP;
         end
         S_RESP: begin
            // The pass after reset has no beat to hand over.
            if (rsp.ready || from_reset_ff) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      rsp_in.cursor_now = cur_in;
      rsp_in.fill_now   = fill_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cur_ff   <= '0;
         fill_ff  <= '0;
         cnt_ff   <= '0;
         phase_ff <= 1'b0;
         req_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         fill_ff  <= fill_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
         req_ff   <= req_in;
      end
      amt_ff  <= amt_in;
      rsp_ff  <= rsp_in;
   end

   assign req.ready = (state_ff == S_IDLE);
   // The clearing pass after reset produces no beat.
   always_ff @(posedge clock) begin
      if (reset) from_reset_ff <= 1'b1;
      else if (state_ff == S_IDLE) from_reset_ff <= 1'b0;
   end
   assign rsp.valid = (state_ff == S_RESP) && !from_reset_ff;
   assign rsp.data  = rsp_ff;

`ifndef ASSERT_OFF
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("request taken while response pending");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= PW'(bofm_pkg::DEPTH)) else $error("fill beyond store depth");
   a_cur_bound: assert property (@(posedge clock) disable iff (reset)
      cur_ff <= fill_ff) else $error("cursor beyond fill");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("response beat changed while stalled");
`endif

endmodule
